>>> sv/mclg_pkg.sv
package mclg_pkg;

    localparam int MAX_MIPS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 168;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_BLOCK_IS_4X4 = 1'b0;
    localparam logic REG_BLOCK_BYTES  = 1'b1;

    localparam logic [5:0] BLOCK_BYTES_RST = 6'd4;
    localparam logic [20:0] STRIDE_SAT     = 21'h1F_FFFF;
    localparam logic [32:0] ACC_LIMIT      = 33'h1_0000_0000;

    typedef struct packed {
        logic       big;
        logic [5:0] bytes;
    } t_cfg;

    // one normalised texture descriptor waiting in the queue
    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic [11:0] d;
        logic [11:0] layers;
        logic [4:0]  count;
        logic        big;
        logic [5:0]  bytes;
    } t_desc;

    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] level_width;
        logic [15:0] level_height;
        logic [11:0] level_depth;
        logic [16:0] row_length;
        logic [16:0] image_height;
        logic [20:0] row_byte_stride;
        logic [31:0] level_offset;
        logic [31:0] total_size;
        logic        overflow;
        logic        last;
    } t_res;

    function automatic logic [15:0] halve16(input logic [15:0] v);
        return (v[15:1] == 15'd0) ? 16'd1 : {1'b0, v[15:1]};
    endfunction

    function automatic logic [11:0] halve12(input logic [11:0] v);
        return (v[11:1] == 11'd0) ? 12'd1 : {1'b0, v[11:1]};
    endfunction

    function automatic logic [15:0] blocks(input logic [15:0] v, input logic big);
        logic [16:0] r;
        r = (17'(v) + 17'd3) >> 2;
        return big ? r[15:0] : v;
    endfunction

endpackage

>>> sv/mip_chain_layout_generator_top.sv
// mip chain layout generator
// slave stream: one texture descriptor per beat; tdata holds base_width [15:0],
// base_height [31:16], base_depth [43:32], layer_count [55:44], mip_count [60:56].
// master stream: one beat per mip level in order; tlast on the final level, tuser
// carries the overflow flag, tdata packs the level's extent, rounded row length and
// image height, row byte stride, packed offset and (on the last beat) the total.
// apb port: block_is_4x4 at 0x0, block_bytes at 0x4; write only while idle.
// flow: a descriptor is taken whenever the descriptor queue has room; the level
// sequencer loads a descriptor in its idle step and then, for each level, runs
// two registered multiply steps and the emit step.
// a mip_count of zero gives no beats at all.
// when the receiver stalls, the output register holds its beat and the sequencer
// waits in its emit step; the queue keeps taking descriptors until it is full.
// reset empties the queue and the sequencer and restores block_is_4x4 = 0 and
// block_bytes = 4.
module mip_chain_layout_generator_top
    import mclg_pkg::*;
#(
    parameter int MAX_MIPS    = MAX_MIPS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // base_width, base_height, base_depth, layer_count, mip_count, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // level, level_width, level_height, level_depth, row_length, image_height,
    // row_byte_stride, level_offset, total_size, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    // overflow
    output logic                   o_m_axis_tuser
);

    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_desc desc_in;
    t_desc desc_out;
    t_res  res;

    mclg_front #(
        .MAX_MIPS (MAX_MIPS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_desc  (desc_in),
        .i_full  (full)
    );

    mclg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (desc_out),
        .o_empty (empty)
    );

    mclg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_desc  (desc_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {1'b0, res.total_size, res.level_offset, res.row_byte_stride,
                             res.image_height, res.row_length, res.level_depth,
                             res.level_height, res.level_width, res.level};
    assign o_m_axis_tlast = res.last;
    assign o_m_axis_tuser = res.overflow;

endmodule

>>> sv/mclg_fifo.sv
module mclg_fifo
    import mclg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with pointers apart");

endmodule

>>> sv/mclg_front.sv
module mclg_front
    import mclg_pkg::*;
#(
    parameter int MAX_MIPS = MAX_MIPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_valid,
    input  logic [IN_TDATA_W-1:0]  i_data,
    output logic                   o_ready,
    output logic                   o_push,
    output t_desc                  o_desc,
    input  logic                   i_full
);

    localparam int CAP = (MAX_MIPS < 16) ? MAX_MIPS : 16;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [4:0] count_in;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.big   <= 1'b0;
            r_cfg.bytes <= BLOCK_BYTES_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BLOCK_IS_4X4: r_cfg.big   <= pwdata[0];
                REG_BLOCK_BYTES:  r_cfg.bytes <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCK_IS_4X4: prdata = APB_DATA_W'(r_cfg.big);
            REG_BLOCK_BYTES:  prdata = APB_DATA_W'(r_cfg.bytes);
            default:          prdata = '0;
        endcase
    end

    assign count_in = i_data[60:56];
    assign o_ready  = !i_full;
    // a descriptor with no levels gives no results and never enters the queue
    assign o_push   = i_valid && !i_full && (count_in != 5'd0);

    always_comb begin
        o_desc.w      = (i_data[15:0] == 16'd0) ? 16'd1 : i_data[15:0];
        o_desc.h      = (i_data[31:16] == 16'd0) ? 16'd1 : i_data[31:16];
        o_desc.d      = (i_data[43:32] == 12'd0) ? 12'd1 : i_data[43:32];
        o_desc.layers = i_data[55:44];
        o_desc.count  = (count_in > 5'(CAP)) ? 5'(CAP) : count_in;
        o_desc.big    = r_cfg.big;
        o_desc.bytes  = r_cfg.bytes;
    end

endmodule

>>> sv/mclg_back.sv
module mclg_back
    import mclg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_desc i_desc,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } t_state;

    t_state       r_state;
    logic [15:0]  r_w;
    logic [15:0]  r_h;
    logic [11:0]  r_d;
    logic [4:0]   r_count;
    logic [4:0]   r_level;
    logic         r_big;
    logic [5:0]   r_bytes;
    logic [17:0]  r_lb;
    logic [31:0]  r_pa;
    logic [29:0]  r_pd;
    logic [61:0]  r_size;
    logic [20:0]  r_stride;
    logic [32:0]  r_acc;
    logic         r_valid;
    t_res         r_res;

    logic [15:0]  bw;
    logic [15:0]  bh;
    logic [21:0]  stride_raw;
    logic [32:0]  size_c;
    logic [33:0]  sum;
    logic [32:0]  acc_new;
    logic         is_last;
    logic         can_load;

    assign bw         = blocks(r_w, r_big);
    assign bh         = blocks(r_h, r_big);
    assign stride_raw = 22'(bw) * 22'(r_bytes);
    assign size_c     = (r_size[61:32] != 30'd0) ? ACC_LIMIT : {1'b0, r_size[31:0]};
    assign sum        = {1'b0, r_acc} + {1'b0, size_c};
    assign acc_new    = (sum > {1'b0, ACC_LIMIT}) ? ACC_LIMIT : sum[32:0];
    assign is_last    = ((r_level + 5'd1) == r_count);
    assign can_load   = !r_valid || i_ready;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && can_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_w     <= i_desc.w;
                        r_h     <= i_desc.h;
                        r_d     <= i_desc.d;
                        r_count <= i_desc.count;
                        r_big   <= i_desc.big;
                        r_bytes <= i_desc.bytes;
                        r_lb    <= 18'(i_desc.layers) * 18'(i_desc.bytes);
                        r_level <= '0;
                        r_acc   <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_pa     <= 32'(bw) * 32'(bh);
                    r_pd     <= 30'(r_d) * 30'(r_lb);
                    r_stride <= stride_raw[21] ? STRIDE_SAT : stride_raw[20:0];
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_size  <= 62'(r_pa) * 62'(r_pd);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_res.level          <= r_level[3:0];
                        r_res.level_width    <= r_w;
                        r_res.level_height   <= r_h;
                        r_res.level_depth    <= r_d;
                        r_res.row_length     <= r_big ? {bw[14:0], 2'b00} : {1'b0, bw};
                        r_res.image_height   <= r_big ? {bh[14:0], 2'b00} : {1'b0, bh};
                        r_res.row_byte_stride <= r_stride;
                        r_res.level_offset   <= r_acc[32] ? 32'hFFFF_FFFF : r_acc[31:0];
                        r_res.total_size     <= !is_last ? 32'd0 :
                                                (acc_new[32] ? 32'hFFFF_FFFF : acc_new[31:0]);
                        r_res.overflow       <= acc_new[32];
                        r_res.last           <= is_last;
                        r_acc   <= acc_new;
                        r_w     <= halve16(r_w);
                        r_h     <= halve16(r_h);
                        r_d     <= halve12(r_d);
                        r_level <= r_level + 5'd1;
                        r_state <= is_last ? S_IDLE : S_MUL1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> (r_level < r_count))
        else $error("level index past the run length");

    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.last) |-> (r_res.total_size == 32'd0))
        else $error("total size shown before the final level");

endmodule
